// File: sv/cdc_pkg.sv
// Shared types, constants and month-length lookup for the calendar date counter.
`timescale 1ns / 1ps
`default_nettype none
package cdc_pkg;

  localparam int YEAR_BITS_DEF = 16;

  localparam logic [4:0]  DEF_DAY   = 5'd1;
  localparam logic [3:0]  DEF_MONTH = 4'd1;
  localparam logic [15:0] DEF_YEAR  = 16'd2023;
  localparam logic [3:0]  DEC_MONTH = 4'd12;
  localparam logic [4:0]  DEC_DAYS  = 5'd31;
  localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
  localparam logic [3:0]  FEB = 4'd2;

  // Multiplicative inverse of 25 modulo 2^32; low bits serve any narrower width.
  localparam logic [31:0] INV25 = 32'hC28F5C29;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        load_rejected;
    logic        range_overflow;
  } date_t;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days in month m (1..12); out-of-range months give 31 and are screened by callers.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = m - 4'd1;
    if (idx < 4'd12) begin
      len = MONTH_DAYS[idx];
    end else begin
      len = DEC_DAYS;
    end
    if (leap && (m == FEB)) begin
      len = FEB_LEAP_DAYS;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: sv/calendar_date_counter.sv
// Top level of the Gregorian calendar date counter: input and result registers around the core.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one transaction: an opcode
//   (load, next day, previous day, read) and the date fields used by a load.
//   date channel (date_valid/date_ready/date) returns exactly one result per
//   transaction: the date after the operation plus load_rejected and
//   range_overflow flags.
//   An accepted cmd is written into the input register; the date update is
//   then written into the result register when that register may advance
//   (it is empty or date_ready is high).
//   Throughput is one transaction per cycle while date_ready is high; it is set by
//   the date state registers, which update once per transaction in a single pass.
//   When date_ready is low the result register holds and the input register
//   fills; cmd_ready then drops until the result is taken.
//   Reset (rst, synchronous) empties both registers and sets the date to
//   1 January 2023.
//   A rejected load stores 1 January 2023; a step past the year range
//   holds the date.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_counter #(
  parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire cdc_pkg::cmd_t  cmd,
  output logic                date_valid,
  input  wire logic           date_ready,
  output cdc_pkg::date_t      date
);

  logic           s1_valid;
  cdc_pkg::cmd_t  s1_cmd;
  logic           advance;
  logic           fire;
  cdc_pkg::date_t result;

  assign advance   = !date_valid || date_ready;
  assign fire      = s1_valid && advance;
  assign cmd_ready = !s1_valid || advance;

  cdc_core #(.YEAR_BITS(YEAR_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .item   (s1_cmd),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      date_valid <= 1'b0;
    end else begin
      if (cmd_ready) begin
        s1_valid <= cmd_valid;
      end
      if (advance) begin
        date_valid <= s1_valid;
      end
    end
    if (cmd_ready && cmd_valid) begin
      s1_cmd <= cmd;
    end
    if (fire) begin
      date <= result;
    end
  end

endmodule
`default_nettype wire

// File: sv/cdc_leap.sv
// Gregorian leap-year detector: divisibility by 4, 16 and 25 without a divider.
`timescale 1ns / 1ps
`default_nettype none
module cdc_leap #(
  parameter int W = cdc_pkg::YEAR_BITS_DEF
) (
  input  wire logic [W-1:0] year,
  output logic              leap
);

  localparam logic [63:0] THR64 = ((64'd1 << W) - 64'd1) / 64'd25;
  localparam logic [W-1:0] THR  = THR64[W-1:0];
  localparam logic [W-1:0] INV  = cdc_pkg::INV25[W-1:0];

  logic [W-1:0] prod;
  logic         div4;
  logic         div16;
  logic         div25;

  // x divisible by 25 iff x * inv(25) mod 2^W <= (2^W - 1) / 25
  assign prod  = year * INV;
  assign div25 = (prod <= THR);
  assign div4  = (year[1:0] == 2'd0);
  assign div16 = (year[3:0] == 4'd0);
  assign leap  = (div4 && !div25) || (div16 && div25);

endmodule
`default_nettype wire

// File: sv/cdc_core.sv
// Date state registers and single-pass date update logic (load, next day, previous day, read) for one transaction.
`timescale 1ns / 1ps
`default_nettype none
module cdc_core #(
  parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire cdc_pkg::cmd_t item,
  output cdc_pkg::date_t     result
);

  localparam int LW = (YEAR_BITS > 16) ? YEAR_BITS : 16;

  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic [4:0]           cur_day_next;
  logic [3:0]           cur_month_next;
  logic [YEAR_BITS-1:0] cur_year_next;

  logic          leap_cur;
  logic          leap_ld;
  logic [4:0]    cur_len;
  logic [4:0]    prev_len;
  logic [4:0]    ld_len;
  logic [LW-1:0] ly_ext;
  logic [LW-1:0] ymax;
  logic          ld_ok;
  logic          rejected;
  logic          overflow;

  cdc_leap #(.W(YEAR_BITS)) u_leap_cur (
    .year (cur_year),
    .leap (leap_cur)
  );

  cdc_leap #(.W(16)) u_leap_ld (
    .year (item.load_year),
    .leap (leap_ld)
  );

  assign ly_ext   = LW'(item.load_year);
  assign ymax     = LW'({YEAR_BITS{1'b1}});
  assign cur_len  = cdc_pkg::month_len(cur_month, leap_cur);
  assign prev_len = cdc_pkg::month_len(cur_month - 4'd1, leap_cur);
  assign ld_len   = cdc_pkg::month_len(item.load_month, leap_ld);
  assign ld_ok    = (item.load_month >= 4'd1) && (item.load_month <= cdc_pkg::DEC_MONTH) &&
                    (ly_ext <= ymax) && (item.load_day >= 5'd1) &&
                    (item.load_day <= ld_len);

  always_comb begin
    cur_day_next   = cur_day;
    cur_month_next = cur_month;
    cur_year_next  = cur_year;
    rejected       = 1'b0;
    overflow       = 1'b0;
    unique case (item.opcode)
      cdc_pkg::OP_LOAD: begin
        if (ld_ok) begin
          cur_day_next   = item.load_day;
          cur_month_next = item.load_month;
          cur_year_next  = YEAR_BITS'(ly_ext);
        end else begin
          cur_day_next   = cdc_pkg::DEF_DAY;
          cur_month_next = cdc_pkg::DEF_MONTH;
          cur_year_next  = YEAR_BITS'(cdc_pkg::DEF_YEAR);
          rejected       = 1'b1;
        end
      end
      cdc_pkg::OP_NEXT: begin
        if (cur_day < cur_len) begin
          cur_day_next = cur_day + 5'd1;
        end else if (cur_month < cdc_pkg::DEC_MONTH) begin
          cur_day_next   = 5'd1;
          cur_month_next = cur_month + 4'd1;
        end else if (cur_year != {YEAR_BITS{1'b1}}) begin
          cur_day_next   = 5'd1;
          cur_month_next = 4'd1;
          cur_year_next  = cur_year + YEAR_BITS'(1);
        end else begin
          overflow = 1'b1;
        end
      end
      cdc_pkg::OP_PREV: begin
        if (cur_day > 5'd1) begin
          cur_day_next = cur_day - 5'd1;
        end else if (cur_month > 4'd1) begin
          cur_month_next = cur_month - 4'd1;
          cur_day_next   = prev_len;
        end else if (cur_year != '0) begin
          cur_year_next  = cur_year - YEAR_BITS'(1);
          cur_month_next = cdc_pkg::DEC_MONTH;
          cur_day_next   = cdc_pkg::DEC_DAYS;
        end else begin
          overflow = 1'b1;
        end
      end
      cdc_pkg::OP_READ: begin
      end
    endcase
  end

  always_comb begin
    result.day_out        = cur_day_next;
    result.month_out      = cur_month_next;
    result.year_out       = 16'(cur_year_next);
    result.load_rejected  = rejected;
    result.range_overflow = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= cdc_pkg::DEF_DAY;
      cur_month <= cdc_pkg::DEF_MONTH;
      cur_year  <= YEAR_BITS'(cdc_pkg::DEF_YEAR);
    end else if (en) begin
      cur_day   <= cur_day_next;
      cur_month <= cur_month_next;
      cur_year  <= cur_year_next;
    end
  end

endmodule
`default_nettype wire
